// ----- hdl/scic_pkg.sv -----
// Package for the scanline IRQ counter with prescaler.
// Holds opcodes, register numbers, control bit positions and counter constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scic_pkg;

    localparam int OPCODE_W   = 1;
    localparam int REG_SEL_W  = 4;
    localparam int DATA_W     = 8;
    localparam int CTRL_W     = 3;
    localparam int PRESCALE_W = 10;

    typedef logic [OPCODE_W-1:0]         opcode_t;
    typedef logic [REG_SEL_W-1:0]        reg_sel_t;
    typedef logic [DATA_W-1:0]           data_t;
    typedef logic [CTRL_W-1:0]           ctrl_t;
    typedef logic signed [PRESCALE_W-1:0] prescale_t;

    localparam opcode_t OP_WRITE = 1'b0;
    localparam opcode_t OP_TICK  = 1'b1;

    localparam reg_sel_t REG_CONTROL = 4'hD;
    localparam reg_sel_t REG_ACK     = 4'hE;
    localparam reg_sel_t REG_LATCH   = 4'hF;

    localparam int CTRL_ACK_BIT    = 0;
    localparam int CTRL_ENABLE_BIT = 1;
    localparam int CTRL_CYCLE_BIT  = 2;

    localparam prescale_t PRESCALE_LOAD = 10'sd341;
    localparam prescale_t PRESCALE_STEP = 10'sd3;
    localparam data_t     COUNT_MAX     = 8'hFF;

endpackage

`default_nettype wire

// ----- hdl/scic_if.sv -----
// Valid/ready channel interfaces for the scanline IRQ counter.
// Depends on scic_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface scic_cmd_if;
    logic                valid;
    logic                ready;
    scic_pkg::opcode_t   opcode;
    scic_pkg::reg_sel_t  reg_select;
    scic_pkg::data_t     write_value;

    modport source (output valid, output opcode, output reg_select, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input reg_select, input write_value,
                    output ready);
endinterface

interface scic_status_if;
    logic             valid;
    logic             ready;
    logic             irq_pending;
    scic_pkg::data_t  count_now;

    modport source (output valid, output irq_pending, output count_now, input ready);
    modport sink   (input valid, input irq_pending, input count_now, output ready);
endinterface

`default_nettype wire

// ----- hdl/scanline_irq_counter_prescaler_unit.sv -----
// Top level of the scanline IRQ counter: 8-bit up counter, reload latch, prescaler.
// Depends on scic_pkg and the channel interfaces in scic_if.sv.
//
//   channel  | dir | payload                              | role
//   cmd      | in  | opcode, reg_select, write_value      | register write or CPU tick
//   status   | out | irq_pending, count_now               | one status item per cmd item
//
// One cmd item is accepted per clock unless cmd is held off; its status item is
// in the result register in the next cycle. The status register is the only
// stage, so cmd is held off only while a status item waits and status.ready is low.
// rst_n clears the counter state and drops any waiting status item.
`timescale 1ns / 1ps
`default_nettype none

module scanline_irq_counter_prescaler_unit (
    input  wire            clk,
    input  wire            rst_n,
    scic_cmd_if.sink       cmd,
    scic_status_if.source  status
);

    scic_pkg::ctrl_t     ctrl_reg,   ctrl_next;
    scic_pkg::data_t     count_reg,  count_next;
    scic_pkg::data_t     latch_reg,  latch_next;
    scic_pkg::prescale_t presc_reg,  presc_next;
    logic                irq_reg,    irq_next;

    logic                res_valid_reg, res_valid_next;
    logic                res_irq_reg;
    scic_pkg::data_t     res_count_reg;

    scic_pkg::prescale_t presc_dec;
    logic                bump;
    logic                accept;

    assign cmd.ready = !res_valid_reg || status.ready;
    assign accept    = cmd.valid && cmd.ready;

    assign status.valid       = res_valid_reg;
    assign status.irq_pending = res_irq_reg;
    assign status.count_now   = res_count_reg;

    assign presc_dec = presc_reg - scic_pkg::PRESCALE_STEP;

    always_comb
    begin
        ctrl_next  = ctrl_reg;
        count_next = count_reg;
        latch_next = latch_reg;
        presc_next = presc_reg;
        irq_next   = irq_reg;
        bump       = 1'b0;
        if (accept)
        begin
            if (cmd.opcode == scic_pkg::OP_TICK)
            begin
                if (ctrl_reg[scic_pkg::CTRL_ENABLE_BIT])
                begin
                    if (ctrl_reg[scic_pkg::CTRL_CYCLE_BIT])
                    begin
                        bump = 1'b1;
                    end
                    else if (presc_dec <= 10'sd0)
                    begin
                        presc_next = presc_dec + scic_pkg::PRESCALE_LOAD;
                        bump       = 1'b1;
                    end
                    else
                    begin
                        presc_next = presc_dec;
                    end
                end
                if (bump)
                begin
                    if (count_reg == scic_pkg::COUNT_MAX)
                    begin
                        count_next = latch_reg;
                        irq_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
            end
            else
            begin
                unique case (cmd.reg_select)
                    scic_pkg::REG_CONTROL:
                    begin
                        ctrl_next = cmd.write_value[scic_pkg::CTRL_W-1:0];
                        if (cmd.write_value[scic_pkg::CTRL_ENABLE_BIT])
                        begin
                            count_next = latch_reg;
                            presc_next = scic_pkg::PRESCALE_LOAD;
                        end
                        irq_next = 1'b0;
                    end
                    scic_pkg::REG_ACK:
                    begin
                        ctrl_next[scic_pkg::CTRL_ENABLE_BIT] =
                            ctrl_reg[scic_pkg::CTRL_ACK_BIT];
                        irq_next = 1'b0;
                    end
                    scic_pkg::REG_LATCH:
                    begin
                        latch_next = cmd.write_value;
                    end
                    default:
                    begin
                        ctrl_next = ctrl_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (status.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            count_reg     <= '0;
            latch_reg     <= '0;
            presc_reg     <= '0;
            irq_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg      <= ctrl_next;
            count_reg     <= count_next;
            latch_reg     <= latch_next;
            presc_reg     <= presc_next;
            irq_reg       <= irq_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_irq_reg   <= irq_next;
            res_count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/scic_checker.sv -----
// Port-level checks for scanline_irq_counter_prescaler_unit, with its bind.
// Depends on scic_pkg; sees only the top level's channel signals.
`timescale 1ns / 1ps
`default_nettype none

module scic_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      cmd_valid,
    input wire                      cmd_ready,
    input wire scic_pkg::opcode_t   cmd_opcode,
    input wire scic_pkg::reg_sel_t  cmd_reg_select,
    input wire                      status_valid,
    input wire                      status_ready,
    input wire                      status_irq_pending,
    input wire scic_pkg::data_t     status_count_now
);

    logic cmd_accept;
    logic clear_write;

    assign cmd_accept  = cmd_valid && cmd_ready;
    assign clear_write = cmd_accept && (cmd_opcode == scic_pkg::OP_WRITE) &&
                         ((cmd_reg_select == scic_pkg::REG_CONTROL) ||
                          (cmd_reg_select == scic_pkg::REG_ACK));

    a_item_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> status_valid)
        else $error("accepted item produced no status item");

    a_clear_drops_irq: assert property (@(posedge clk) disable iff (!rst_n)
        clear_write |=> !status_irq_pending)
        else $error("control or acknowledge write left irq pending");

    a_status_held: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && !status_ready |=> status_valid)
        else $error("status item dropped while stalled");

    a_status_stable: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && !status_ready |=>
            $stable(status_irq_pending) && $stable(status_count_now))
        else $error("status payload changed while stalled");

endmodule

bind scanline_irq_counter_prescaler_unit scic_checker u_scic_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .cmd_opcode         (cmd.opcode),
    .cmd_reg_select     (cmd.reg_select),
    .status_valid       (status.valid),
    .status_ready       (status.ready),
    .status_irq_pending (status.irq_pending),
    .status_count_now   (status.count_now)
);

`default_nettype wire
